[sv/lcas_pkg.sv]
`timescale 1ns / 1ps

package lcas_pkg;

    localparam int HW_LIMIT     = 32;
    localparam int DEF_MAX_COLS = 32;
    localparam int DEF_MAX_ROWS = 32;

    localparam int CFG_W      = 6;
    localparam int IDX_W      = 5;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [CFG_W-1:0] SIZE_RESET = 6'd32;

    localparam logic [3:0] SURVIVE_LOW = 4'd2;
    localparam logic [3:0] BIRTH_COUNT = 4'd3;

    localparam logic REG_GRID_ROWS = 1'b0;
    localparam logic REG_GRID_COLS = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_EVAL   = 4'b0010,
        ST_EMIT_A = 4'b0100,
        ST_EMIT_B = 4'b1000
    } state_t;

    typedef struct packed {
        logic accept;
        logic emit;
        logic sel_b;
        logic shift;
        logic clear;
    } cmd_t;

    typedef struct packed {
        logic col_last;
        logic row_first;
        logic row_last;
        logic emit_last;
        logic out_free;
    } status_t;

    function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
                                                   input logic [CFG_W-1:0] top);
        logic [CFG_W-1:0] r;
        begin
            if (v == '0)
            begin
                r = 6'd1;
            end
            else if (v > top)
            begin
                r = top;
            end
            else
            begin
                r = v;
            end
            return r;
        end
    endfunction

endpackage

[sv/life_cellular_automaton_step_unit.sv]
`timescale 1ns / 1ps

// channel   direction  handshake                    payload
// in        input      in_valid / in_ready          cell_alive
// out       output     out_valid / out_ready        next_alive, out_row, out_col,
//                                                   run_last, generation_end
// cfg       input      psel / penable / pwrite      paddr, pwdata, prdata (pready tied high)
//
// cells are taken while idle; the last cell of a row is followed by a decode state
// a finished row then drains through the output register, one result per cycle unless stalled
// in_ready is low while a row drains; out_ready low stalls the drain in place
// reset sets both sizes to 32 and clears the row stores and counters at once
// any register write restarts the generation

module life_cellular_automaton_step_unit #(
    parameter int MAX_COLS = lcas_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = lcas_pkg::DEF_MAX_ROWS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lcas_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [lcas_pkg::APB_DATA_W-1:0] pwdata,
    output logic [lcas_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            cell_alive,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            next_alive,
    output logic [lcas_pkg::IDX_W-1:0]      out_row,
    output logic [lcas_pkg::IDX_W-1:0]      out_col,
    output logic                            run_last,
    output logic                            generation_end
);

    logic                       cfg_wr;
    logic [lcas_pkg::CFG_W-1:0] rows_eff;
    logic [lcas_pkg::CFG_W-1:0] cols_eff;
    lcas_pkg::cmd_t             cmd;
    lcas_pkg::status_t          status;

    assign pready = 1'b1;

    lcas_cfg #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .cfg_wr   (cfg_wr),
        .rows_eff (rows_eff),
        .cols_eff (cols_eff)
    );

    lcas_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cfg_wr   (cfg_wr),
        .status   (status),
        .cmd      (cmd)
    );

    lcas_dp #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cell_alive     (cell_alive),
        .cfg_wr         (cfg_wr),
        .rows_eff       (rows_eff),
        .cols_eff       (cols_eff),
        .cmd            (cmd),
        .status         (status),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .next_alive     (next_alive),
        .out_row        (out_row),
        .out_col        (out_col),
        .run_last       (run_last),
        .generation_end (generation_end)
    );

endmodule

[sv/lcas_cfg.sv]
`timescale 1ns / 1ps

module lcas_cfg #(
    parameter int MAX_COLS = lcas_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = lcas_pkg::DEF_MAX_ROWS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [lcas_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [lcas_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [lcas_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               cfg_wr,
    output logic [lcas_pkg::CFG_W-1:0]         rows_eff,
    output logic [lcas_pkg::CFG_W-1:0]         cols_eff
);

    localparam int COL_LIM = (MAX_COLS < lcas_pkg::HW_LIMIT) ? MAX_COLS : lcas_pkg::HW_LIMIT;
    localparam int ROW_LIM = (MAX_ROWS < lcas_pkg::HW_LIMIT) ? MAX_ROWS : lcas_pkg::HW_LIMIT;
    localparam logic [lcas_pkg::CFG_W-1:0] COL_TOP = lcas_pkg::CFG_W'(COL_LIM);
    localparam logic [lcas_pkg::CFG_W-1:0] ROW_TOP = lcas_pkg::CFG_W'(ROW_LIM);

    logic [lcas_pkg::CFG_W-1:0] rows_reg;
    logic [lcas_pkg::CFG_W-1:0] rows_next;
    logic [lcas_pkg::CFG_W-1:0] cols_reg;
    logic [lcas_pkg::CFG_W-1:0] cols_next;
    logic                       reg_sel;

    assign reg_sel = paddr[2];
    assign cfg_wr  = psel & penable & pwrite;

    always_comb
    begin
        rows_next = rows_reg;
        cols_next = cols_reg;
        if (cfg_wr)
        begin
            case (reg_sel)
                lcas_pkg::REG_GRID_ROWS: rows_next = pwdata[lcas_pkg::CFG_W-1:0];
                lcas_pkg::REG_GRID_COLS: cols_next = pwdata[lcas_pkg::CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= lcas_pkg::SIZE_RESET;
            cols_reg <= lcas_pkg::SIZE_RESET;
        end
        else
        begin
            rows_reg <= rows_next;
            cols_reg <= cols_next;
        end
    end

    always_comb
    begin
        case (reg_sel)
            lcas_pkg::REG_GRID_ROWS: prdata = {{(lcas_pkg::APB_DATA_W-lcas_pkg::CFG_W){1'b0}}, rows_reg};
            lcas_pkg::REG_GRID_COLS: prdata = {{(lcas_pkg::APB_DATA_W-lcas_pkg::CFG_W){1'b0}}, cols_reg};
            default:                 prdata = '0;
        endcase
    end

    assign rows_eff = lcas_pkg::clamp_size(rows_reg, ROW_TOP);
    assign cols_eff = lcas_pkg::clamp_size(cols_reg, COL_TOP);

endmodule

[sv/lcas_ctrl.sv]
`timescale 1ns / 1ps

module lcas_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              cfg_wr,
    input  lcas_pkg::status_t status,
    output lcas_pkg::cmd_t    cmd
);

    lcas_pkg::state_t state_reg;
    lcas_pkg::state_t state_next;

    assign in_ready = (state_reg == lcas_pkg::ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            lcas_pkg::ST_IDLE:
            begin
                cmd.accept = in_valid;
                if (in_valid && status.col_last)
                begin
                    state_next = lcas_pkg::ST_EVAL;
                end
            end
            lcas_pkg::ST_EVAL:
            begin
                if (!status.row_first)
                begin
                    state_next = lcas_pkg::ST_EMIT_A;
                end
                else if (status.row_last)
                begin
                    state_next = lcas_pkg::ST_EMIT_B;
                end
                else
                begin
                    cmd.shift  = 1'b1;
                    state_next = lcas_pkg::ST_IDLE;
                end
            end
            lcas_pkg::ST_EMIT_A:
            begin
                cmd.emit = status.out_free;
                if (status.out_free && status.emit_last)
                begin
                    if (status.row_last)
                    begin
                        state_next = lcas_pkg::ST_EMIT_B;
                    end
                    else
                    begin
                        cmd.shift  = 1'b1;
                        state_next = lcas_pkg::ST_IDLE;
                    end
                end
            end
            lcas_pkg::ST_EMIT_B:
            begin
                cmd.emit  = status.out_free;
                cmd.sel_b = 1'b1;
                if (status.out_free && status.emit_last)
                begin
                    cmd.clear  = 1'b1;
                    state_next = lcas_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lcas_pkg::ST_IDLE;
            end
        endcase
        if (cfg_wr)
        begin
            state_next = lcas_pkg::ST_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lcas_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[sv/lcas_dp.sv]
`timescale 1ns / 1ps

module lcas_dp #(
    parameter int MAX_COLS = lcas_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = lcas_pkg::DEF_MAX_ROWS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cell_alive,
    input  logic                           cfg_wr,
    input  logic [lcas_pkg::CFG_W-1:0]     rows_eff,
    input  logic [lcas_pkg::CFG_W-1:0]     cols_eff,
    input  lcas_pkg::cmd_t                 cmd,
    output lcas_pkg::status_t              status,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           next_alive,
    output logic [lcas_pkg::IDX_W-1:0]     out_row,
    output logic [lcas_pkg::IDX_W-1:0]     out_col,
    output logic                           run_last,
    output logic                           generation_end
);

    localparam int COL_LIM = (MAX_COLS < lcas_pkg::HW_LIMIT) ? MAX_COLS : lcas_pkg::HW_LIMIT;
    localparam int ROW_LIM = (MAX_ROWS < lcas_pkg::HW_LIMIT) ? MAX_ROWS : lcas_pkg::HW_LIMIT;
    localparam int CW      = (COL_LIM > 1) ? $clog2(COL_LIM) : 1;
    localparam int RW      = (ROW_LIM > 1) ? $clog2(ROW_LIM) : 1;

    logic [COL_LIM-1:0] s0_reg, s0_next;
    logic [COL_LIM-1:0] s1_reg, s1_next;
    logic [COL_LIM-1:0] s2_reg, s2_next;
    logic [CW-1:0]      col_reg, col_next;
    logic [CW-1:0]      ec_reg, ec_next;
    logic [RW-1:0]      row_reg, row_next;
    logic               out_valid_reg, out_valid_next;

    logic                       alive_reg;
    logic [lcas_pkg::IDX_W-1:0] row_out_reg;
    logic [lcas_pkg::IDX_W-1:0] col_out_reg;
    logic                       last_reg;
    logic                       gend_reg;

    logic [COL_LIM-1:0] above, cur, below;
    logic [COL_LIM+1:0] pa, pc, pb;
    logic [2:0]         wa, wc, wb;
    logic [3:0]         ncount;
    logic               self_alive;
    logic               cell_next;

    assign status.col_last  = (lcas_pkg::CFG_W'(col_reg) + 6'd1) == cols_eff;
    assign status.emit_last = (lcas_pkg::CFG_W'(ec_reg) + 6'd1) == cols_eff;
    assign status.row_first = (row_reg == '0);
    assign status.row_last  = (lcas_pkg::CFG_W'(row_reg) + 6'd1) == rows_eff;
    assign status.out_free  = !out_valid_reg || out_ready;

    // neighborhood window, padded with dead cells at the edges
    always_comb
    begin
        if (cmd.sel_b)
        begin
            above = s1_reg;
            cur   = s2_reg;
            below = '0;
        end
        else
        begin
            above = s0_reg;
            cur   = s1_reg;
            below = s2_reg;
        end
        pa = {1'b0, above, 1'b0};
        pc = {1'b0, cur, 1'b0};
        pb = {1'b0, below, 1'b0};
        wa = pa[ec_reg +: 3];
        wc = pc[ec_reg +: 3];
        wb = pb[ec_reg +: 3];
        self_alive = wc[1];
        ncount = 4'(wa[0]) + 4'(wa[1]) + 4'(wa[2]) + 4'(wc[0]) + 4'(wc[2])
               + 4'(wb[0]) + 4'(wb[1]) + 4'(wb[2]);
        if (self_alive)
        begin
            cell_next = (ncount == lcas_pkg::SURVIVE_LOW) || (ncount == lcas_pkg::BIRTH_COUNT);
        end
        else
        begin
            cell_next = (ncount == lcas_pkg::BIRTH_COUNT);
        end
    end

    always_comb
    begin
        s0_next        = s0_reg;
        s1_next        = s1_reg;
        s2_next        = s2_reg;
        col_next       = col_reg;
        ec_next        = ec_reg;
        row_next       = row_reg;
        out_valid_next = out_valid_reg;

        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            if (status.emit_last)
            begin
                ec_next = '0;
            end
            else
            begin
                ec_next = ec_reg + 1'b1;
            end
        end
        if (cmd.accept)
        begin
            s2_next[col_reg] = cell_alive;
            if (!status.col_last)
            begin
                col_next = col_reg + 1'b1;
            end
        end
        if (cmd.shift)
        begin
            s0_next  = s1_reg;
            s1_next  = s2_reg;
            s2_next  = '0;
            row_next = row_reg + 1'b1;
            col_next = '0;
            ec_next  = '0;
        end
        if (cmd.clear || cfg_wr)
        begin
            s0_next  = '0;
            s1_next  = '0;
            s2_next  = '0;
            row_next = '0;
            col_next = '0;
            ec_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_reg        <= '0;
            s1_reg        <= '0;
            s2_reg        <= '0;
            col_reg       <= '0;
            ec_reg        <= '0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s0_reg        <= s0_next;
            s1_reg        <= s1_next;
            s2_reg        <= s2_next;
            col_reg       <= col_next;
            ec_reg        <= ec_next;
            row_reg       <= row_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            alive_reg   <= cell_next;
            row_out_reg <= cmd.sel_b ? lcas_pkg::IDX_W'(row_reg)
                                     : lcas_pkg::IDX_W'(row_reg - 1'b1);
            col_out_reg <= lcas_pkg::IDX_W'(ec_reg);
            last_reg    <= status.emit_last && (cmd.sel_b || !status.row_last);
            gend_reg    <= status.emit_last && cmd.sel_b;
        end
    end

    assign out_valid      = out_valid_reg;
    assign next_alive     = alive_reg;
    assign out_row        = row_out_reg;
    assign out_col        = col_out_reg;
    assign run_last       = last_reg;
    assign generation_end = gend_reg;

endmodule

[test/tb.sv]
`timescale 1ns / 1ps

module tb;

    typedef struct packed {
        logic       alive;
        logic [4:0] row;
        logic [4:0] col;
        logic       last;
        logic       gen_end;
    } life_cell_t;

    class generation_checker;
        logic [lcas_pkg::CFG_W-1:0] rows_reg;
        logic [lcas_pkg::CFG_W-1:0] cols_reg;
        logic [31:0]      above;
        logic [31:0]      middle;
        logic [31:0]      incoming;
        int unsigned      cur_row;
        int unsigned      cur_col;
        life_cell_t       next_gen_q[$];
        int               mismatches;
        int               failures;
        int               cells_in;
        int               results_out;

        function new();
            rows_reg    = lcas_pkg::SIZE_RESET;
            cols_reg    = lcas_pkg::SIZE_RESET;
            mismatches  = 0;
            failures    = 0;
            cells_in    = 0;
            results_out = 0;
            restart();
        endfunction

        function void restart();
            above    = '0;
            middle   = '0;
            incoming = '0;
            cur_row  = 0;
            cur_col  = 0;
        endfunction

        function int unsigned eff_size(logic [lcas_pkg::CFG_W-1:0] v, int lim);
            int unsigned top;
            top = (lim < lcas_pkg::HW_LIMIT) ? lim : lcas_pkg::HW_LIMIT;
            if (v == '0)
            begin
                return 1;
            end
            return (v > top) ? top : v;
        endfunction

        // any write restarts the generation
        function void write_size(logic idx, logic [lcas_pkg::CFG_W-1:0] v);
            if (idx == lcas_pkg::REG_GRID_ROWS)
            begin
                rows_reg = v;
            end
            else
            begin
                cols_reg = v;
            end
            restart();
        endfunction

        function bit live_at(logic [31:0] bits, int c, int unsigned cols);
            if (c < 0 || c >= int'(cols))
            begin
                return 1'b0;
            end
            return bits[c];
        endfunction

        function int push_row(int unsigned r, logic [31:0] up, logic [31:0] mid,
                              logic [31:0] down, int unsigned cols, bit is_bottom);
            life_cell_t res;
            int         n;
            bit         cur;
            for (int c = 0; c < int'(cols); c++)
            begin
                n = live_at(up, c - 1, cols) + live_at(up, c, cols) + live_at(up, c + 1, cols)
                  + live_at(mid, c - 1, cols) + live_at(mid, c + 1, cols)
                  + live_at(down, c - 1, cols) + live_at(down, c, cols)
                  + live_at(down, c + 1, cols);
                cur = live_at(mid, c, cols);
                res.alive   = cur ? (n == lcas_pkg::SURVIVE_LOW || n == lcas_pkg::BIRTH_COUNT)
                                  : (n == lcas_pkg::BIRTH_COUNT);
                res.row     = r[4:0];
                res.col     = c[4:0];
                res.last    = 1'b0;
                res.gen_end = is_bottom && (c + 1 == int'(cols));
                next_gen_q.push_back(res);
            end
            return cols;
        endfunction

        function void take_cell(logic v);
            int unsigned rows;
            int unsigned cols;
            int          produced;
            rows     = eff_size(rows_reg, lcas_pkg::DEF_MAX_ROWS);
            cols     = eff_size(cols_reg, lcas_pkg::DEF_MAX_COLS);
            produced = 0;
            cells_in++;
            if (cur_row >= rows || cur_col >= cols)
            begin
                restart();
            end
            if (v)
            begin
                incoming[cur_col] = 1'b1;
            end
            if (cur_col + 1 < cols)
            begin
                cur_col++;
                return;
            end
            if (cur_row >= 1)
            begin
                produced += push_row(cur_row - 1, above, middle, incoming, cols, 1'b0);
            end
            if (cur_row + 1 == rows)
            begin
                produced += push_row(cur_row, middle, incoming, '0, cols, 1'b1);
                restart();
            end
            else
            begin
                above    = middle;
                middle   = incoming;
                incoming = '0;
                cur_row++;
                cur_col  = 0;
            end
            if (produced > 0)
            begin
                next_gen_q[next_gen_q.size() - 1].last = 1'b1;
            end
        endfunction

        function void check_result(life_cell_t got);
            life_cell_t want;
            results_out++;
            if (next_gen_q.size() == 0)
            begin
                failures++;
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected result: alive=%0d row=%0d col=%0d last=%0d end=%0d",
                             got.alive, got.row, got.col, got.last, got.gen_end);
                end
                return;
            end
            want = next_gen_q.pop_front();
            if (got.alive !== want.alive || got.row !== want.row || got.col !== want.col
                || got.last !== want.last || got.gen_end !== want.gen_end)
            begin
                failures++;
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("mismatch: expected alive=%0d row=%0d col=%0d last=%0d end=%0d",
                             want.alive, want.row, want.col, want.last, want.gen_end);
                    $display("          actual   alive=%0d row=%0d col=%0d last=%0d end=%0d",
                             got.alive, got.row, got.col, got.last, got.gen_end);
                end
            end
        endfunction

        function int pending();
            return next_gen_q.size();
        endfunction
    endclass

    logic                            clk;
    logic                            rst_n;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [lcas_pkg::APB_ADDR_W-1:0] paddr;
    logic [lcas_pkg::APB_DATA_W-1:0] pwdata;
    logic [lcas_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;
    logic                            in_valid;
    logic                            in_ready;
    logic                            cell_alive;
    logic                            out_valid;
    logic                            out_ready;
    logic                            next_alive;
    logic [lcas_pkg::IDX_W-1:0]      out_row;
    logic [lcas_pkg::IDX_W-1:0]      out_col;
    logic                            run_last;
    logic                            generation_end;

    generation_checker sb = new();

    bit send_gaps    = 1'b0;
    bit recv_stalls  = 1'b0;
    int idle_pct     = 59;
    int hold_request = 0;
    int hold_left    = 0;

    life_cellular_automaton_step_unit u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .cell_alive     (cell_alive),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .next_alive     (next_alive),
        .out_row        (out_row),
        .out_col        (out_col),
        .run_last       (run_last),
        .generation_end (generation_end)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

    // receiver pacing, with long hold-offs on request
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (recv_stalls)
            begin
                out_ready <= ($urandom_range(0, 99) >= idle_pct);
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (out_valid && out_ready)
            begin
                sb.check_result('{next_alive, out_row, out_col, run_last, generation_end});
            end
            if (in_valid && in_ready)
            begin
                sb.take_cell(cell_alive);
            end
        end
    end

    task automatic write_reg(input logic idx, input logic [lcas_pkg::CFG_W-1:0] v);
        logic [lcas_pkg::APB_DATA_W-1:0] word;
        word          = $urandom;
        word[lcas_pkg::CFG_W-1:0] = v;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.write_size(idx, v);
    endtask

    task automatic send_cell(input logic v);
        @(negedge clk);
        if (send_gaps && $urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
            while ($urandom_range(0, 99) < idle_pct)
            begin
                @(negedge clk);
            end
        end
        in_valid   <= 1'b1;
        cell_alive <= v;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
    endtask

    task automatic feed_cells(input int count, input int density);
        for (int i = 0; i < count; i++)
        begin
            send_cell($urandom_range(0, 99) < density);
        end
    endtask

    // stop offering and let every pending result drain
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic run_grid(input logic [lcas_pkg::CFG_W-1:0] rows_v,
                            input logic [lcas_pkg::CFG_W-1:0] cols_v,
                            input int count, input int density);
        settle();
        write_reg(lcas_pkg::REG_GRID_ROWS, rows_v);
        write_reg(lcas_pkg::REG_GRID_COLS, cols_v);
        feed_cells(count, density);
    endtask

    initial
    begin
        logic [8:0] blinker;
        blinker    = 9'b010_010_010;
        rst_n      = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        in_valid   = 1'b0;
        cell_alive = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // zero sizes act as a single cell
        write_reg(lcas_pkg::REG_GRID_ROWS, 6'd0);
        write_reg(lcas_pkg::REG_GRID_COLS, 6'd0);
        send_cell(1'b1);
        send_cell(1'b0);

        // partial generation, then a rewrite must restart it
        settle();
        write_reg(lcas_pkg::REG_GRID_ROWS, 6'd3);
        write_reg(lcas_pkg::REG_GRID_COLS, 6'd3);
        send_cell(1'b1);
        send_cell(1'b1);
        send_cell(1'b1);
        settle();
        write_reg(lcas_pkg::REG_GRID_COLS, 6'd3);
        for (int i = 0; i < 9; i++)
        begin
            send_cell(blinker[i]);
        end
        for (int i = 0; i < 9; i++)
        begin
            send_cell(1'b1);
        end

        // no idling
        run_grid(6'd2, 6'd32, 64, 50);
        run_grid(6'd63, 6'd1, 32, 50);

        // sender gaps, with one full drain midway
        settle();
        send_gaps = 1'b1;
        run_grid(6'd5, 6'd5, 25, 45);
        settle();
        feed_cells(15, 45);
        run_grid(6'd1, 6'd7, 21, 40);
        run_grid(6'd40, 6'd3, 30, 35);

        // receiver stalls, starting with a long hold-off
        settle();
        send_gaps   = 1'b0;
        recv_stalls = 1'b1;
        settle();
        write_reg(lcas_pkg::REG_GRID_ROWS, 6'd4);
        write_reg(lcas_pkg::REG_GRID_COLS, 6'd6);
        hold_request = 150;
        feed_cells(60, 40);
        run_grid(6'd32, 6'd2, 20, 50);

        // both sides idle
        settle();
        idle_pct  = 15;
        send_gaps = 1'b1;
        run_grid(6'd3, 6'd4, 36, 45);
        run_grid(6'd1, 6'd33, 40, 40);

        settle();
        repeat (20) @(posedge clk);
        $display("covered %0d cells in and %0d next-generation cells out", sb.cells_in,
                 sb.results_out);
        $display("grids from one cell up to 32 rows or 32 columns, size clamping, restarts,");
        $display("four pacing modes");
        if (sb.failures == 0 && sb.pending() == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

[sim.f]
sv/lcas_pkg.sv
sv/lcas_cfg.sv
sv/lcas_ctrl.sv
sv/lcas_dp.sv
sv/life_cellular_automaton_step_unit.sv
test/tb.sv
